### rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/sbgs_pkg.sv
// Package for the set bipartition Gray sequencer: sizes, frame kinds,
// sequencer states, stack command/view structs and the frame action decode.
// No dependencies.
`timescale 1ns / 1ps

package sbgs_pkg;

    localparam int MAX_ELEMENTS = 32;
    localparam int DEPTH_W      = $clog2(MAX_ELEMENTS + 1);
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int SIZE_W       = 6;

    localparam logic [SIZE_W-1:0] RESET_SIZE    = SIZE_W'(4);
    localparam logic [SIZE_W-1:0] MIN_SIZE      = SIZE_W'(3);
    localparam logic [SIZE_W-1:0] MAX_SIZE      = SIZE_W'(MAX_ELEMENTS);
    localparam logic [SIZE_W-1:0] PUSH_MIN_SIZE = SIZE_W'(4);
    localparam logic [SIZE_W-1:0] LOW_ELEMENT   = SIZE_W'(2);

    typedef logic [1:0] t_step;
    localparam t_step FIRST_STEP = 2'd0;
    localparam t_step LAST_STEP  = 2'd3;

    typedef enum logic [1:0] {
        KIND_ROOT = 2'd0,
        KIND_FWD  = 2'd1,
        KIND_REV  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPLETE,
        ST_SETTLE,
        ST_FINISH
    } t_state;

    // Sequencer -> stack
    typedef struct packed {
        logic  fresh;   // load root frame at depth 0, depth becomes 1
        logic  push;
        logic  pop;
        logic  bump;    // advance top frame step
        t_kind child;
    } t_stack_cmd;

    // Stack -> sequencer
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        t_kind              kind;
        t_step              step;
    } t_stack_view;

    typedef struct packed {
        logic              is_move;
        logic [SIZE_W-1:0] val;
        t_kind             child;
    } t_action;

    // Action of a frame at its current step; s is the frame size.
    function automatic t_action frame_action(t_kind kind, t_step step,
                                             logic [SIZE_W-1:0] s);
        t_action a;
        a.is_move = 1'b0;
        a.val     = '0;
        a.child   = KIND_REV;
        case (kind)
            KIND_ROOT: begin
                case (step)
                    2'd0: begin a.is_move = 1'b1; a.val = s - SIZE_W'(1); end
                    2'd1: a.child = KIND_FWD;
                    2'd2: begin a.is_move = 1'b1; a.val = s; end
                    default: a.child = KIND_REV;
                endcase
            end
            KIND_FWD: begin
                case (step)
                    2'd0: begin a.is_move = 1'b1; a.val = LOW_ELEMENT; end
                    2'd1: a.child = KIND_REV;
                    2'd2: begin a.is_move = 1'b1; a.val = s; end
                    default: a.child = KIND_FWD;
                endcase
            end
            default: begin
                // reverse, and the unused code behaves the same
                case (step)
                    2'd0: a.child = KIND_REV;
                    2'd1: begin a.is_move = 1'b1; a.val = s; end
                    2'd2: a.child = KIND_FWD;
                    default: begin a.is_move = 1'b1; a.val = LOW_ELEMENT; end
                endcase
            end
        endcase
        return a;
    endfunction

endpackage

### rtl/set_bipartition_gray_sequencer_top.sv
// Top level of the set bipartition Gray sequencer: ports, set-size register,
// output register. Depends on sbgs_pkg, sbgs_stack, sbgs_seq.
//
//  channel  | direction | handshake               | payload (low bit first)
//  ---------+-----------+-------------------------+---------------------------
//  s_axis   | in        | i_s_axis_tvalid/tready  | tdata[0] restart
//  m_axis   | out       | o_m_axis_tvalid/tready  | tdata[5:0] moved_element,
//           |           |                         | tlast last_move
//  cfg      | in        | i_cfg_valid/o_cfg_ready | i_cfg_data set_size
//
// Flow: an input is taken in idle; the sequencer then pops or advances the top
//   frame's step, pushes a child or skips the push for a child below size 3, and
//   ends with a final check; pops, step advances and pushes are each bounded by
//   the set size. While the sequencer walks the stack, the frame stack unit does
//   one pop, step or push per cycle.
// Reset: synchronous, active low; set size 4, empty stack, output empty.
// Stalls: a finished move waits in the sequencer until the output register is
//   free; input and config are accepted only while the sequencer is idle, and
//   a pending config write goes first, so input tready drops while cfg is valid.
`timescale 1ns / 1ps

module set_bipartition_gray_sequencer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [0] restart, [7:1] zero
    // output stream
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [5:0] moved_element, [7:6] zero
    output logic       o_m_axis_tlast,   // last_move
    // config write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [5:0] i_cfg_data        // set_size
);
    import sbgs_pkg::*;

    logic [SIZE_W-1:0] r_set_size, n_set_size;
    logic              r_out_valid;
    logic [SIZE_W-1:0] r_out_elem;
    logic              r_out_last;

    t_stack_cmd        cmd;
    t_stack_view       view;
    logic              seq_idle, seq_done, seq_last;
    logic [SIZE_W-1:0] seq_val;
    logic              in_xact, cfg_xact, out_free;

    // config write wins over an input transaction in the same idle cycle
    assign o_s_axis_tready = seq_idle & !i_cfg_valid;
    assign o_cfg_ready     = seq_idle;
    assign in_xact         = i_s_axis_tvalid & o_s_axis_tready;
    assign cfg_xact        = i_cfg_valid & seq_idle;
    // output slot empties this cycle or already is empty
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // set size saturates to the legal range
    always_comb begin
        n_set_size = SIZE_W'(i_cfg_data);
        if (n_set_size < MIN_SIZE) begin
            n_set_size = MIN_SIZE;
        end else if (n_set_size > MAX_SIZE) begin
            n_set_size = MAX_SIZE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_size <= RESET_SIZE;
        end else if (cfg_xact) begin
            r_set_size <= n_set_size;
        end
    end

    // a set-size write also empties the stack (clear in sbgs_stack)
    sbgs_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (cfg_xact),
        .i_cmd   (cmd),
        .o_view  (view)
    );

    sbgs_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_xact),
        .i_restart  (i_s_axis_tdata[0]),
        .i_size     (r_set_size),
        .i_view     (view),
        .i_out_free (out_free),
        .o_cmd      (cmd),
        .o_idle     (seq_idle),
        .o_done     (seq_done),
        .o_val      (seq_val),
        .o_last     (seq_last)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_out_elem <= seq_val;
            r_out_last <= seq_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(8 - SIZE_W)'(0), r_out_elem};
    assign o_m_axis_tlast  = r_out_last;

endmodule

### rtl/sbgs_stack.sv
// Frame stack: kind/step registers per level plus the depth counter.
// Depends on sbgs_pkg.
`timescale 1ns / 1ps

module sbgs_stack (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clear,
    input  sbgs_pkg::t_stack_cmd     i_cmd,
    output sbgs_pkg::t_stack_view    o_view
);
    import sbgs_pkg::*;

    t_kind              r_kind [MAX_ELEMENTS];
    t_step              r_step [MAX_ELEMENTS];
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [IDX_W-1:0]   top_idx, push_idx;

    assign top_idx  = IDX_W'(r_depth - DEPTH_W'(1));
    assign push_idx = r_depth[IDX_W-1:0];

    always_comb begin
        n_depth = r_depth;
        if (i_clear) begin
            n_depth = '0;
        end else if (i_cmd.fresh) begin
            n_depth = DEPTH_W'(1);
        end else if (i_cmd.push) begin
            n_depth = r_depth + DEPTH_W'(1);
        end else if (i_cmd.pop) begin
            n_depth = r_depth - DEPTH_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    // frame storage, no reset: only levels below depth are ever used
    always_ff @(posedge i_clk) begin
        if (i_cmd.fresh) begin
            r_kind[0] <= KIND_ROOT;
            r_step[0] <= FIRST_STEP;
        end else if (i_cmd.push) begin
            r_kind[push_idx] <= i_cmd.child;
            r_step[push_idx] <= FIRST_STEP;
        end else if (i_cmd.bump) begin
            r_step[top_idx] <= r_step[top_idx] + t_step'(1);
        end
    end

    assign o_view.depth = r_depth;
    assign o_view.kind  = r_kind[top_idx];
    assign o_view.step  = r_step[top_idx];

endmodule

### rtl/sbgs_seq.sv
// Sequencer: walks the frame stack one pop, step or push per cycle
// until the next move is on top or the stack is empty. Depends on sbgs_pkg.
`timescale 1ns / 1ps

module sbgs_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_restart,
    input  logic [sbgs_pkg::SIZE_W-1:0] i_size,
    input  sbgs_pkg::t_stack_view       i_view,
    input  logic                        i_out_free,
    output sbgs_pkg::t_stack_cmd        o_cmd,
    output logic                        o_idle,
    output logic                        o_done,
    output logic [sbgs_pkg::SIZE_W-1:0] o_val,
    output logic                        o_last
);
    import sbgs_pkg::*;

    t_state            r_state, n_state;
    logic [SIZE_W-1:0] r_val, n_val;
    logic [SIZE_W-1:0] frame_size;
    logic              empty;
    t_action           act;

    // size of top frame: n - (depth - 1)
    assign frame_size = i_size - SIZE_W'(i_view.depth) + SIZE_W'(1);
    assign empty      = (i_view.depth == '0);
    assign act        = frame_action(i_view.kind, i_view.step, frame_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    always_comb begin
        n_state     = r_state;
        n_val       = r_val;
        o_cmd       = '0;
        o_cmd.child = act.child;
        o_done      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_restart || empty) begin
                        o_cmd.fresh = 1'b1;
                        n_val       = i_size - SIZE_W'(1);   // root opens with n-1
                    end else begin
                        n_val = act.val;
                    end
                    n_state = ST_COMPLETE;
                end
            end
            ST_COMPLETE: begin
                if (empty) begin
                    n_state = ST_SETTLE;
                end else if (i_view.step == LAST_STEP) begin
                    o_cmd.pop = 1'b1;
                end else begin
                    o_cmd.bump = 1'b1;
                    n_state    = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                if (empty || act.is_move) begin
                    n_state = ST_FINISH;
                end else if (frame_size >= PUSH_MIN_SIZE &&
                             i_view.depth < DEPTH_W'(MAX_ELEMENTS)) begin
                    o_cmd.push = 1'b1;
                end else begin
                    // child too small: the push counts as done at once
                    n_state = ST_COMPLETE;
                end
            end
            ST_FINISH: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_idle = (r_state == ST_IDLE);
    assign o_val  = r_val;
    assign o_last = empty;

endmodule

### rtl/sbgs_checker.sv
// Port-level checker for the set bipartition Gray sequencer, bound to the top.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbgs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic [7:0] i_s_axis_tdata,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready,
    input logic [5:0] i_cfg_data
);

    // a stalled result holds
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "stalled output changed")

    // the block is busy for at least the cycle after a transaction
    `ASSERT_RST(a_busy_after_in, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready && !o_cfg_ready, "ready right after input transaction")

    // moved element always lies in 2..32
    `ASSERT_RST(a_elem_range, i_clk, i_rst_n, o_m_axis_tvalid |-> o_m_axis_tdata >= 8'd2 && o_m_axis_tdata <= 8'd32, "moved element out of range")

    // output empties on reset
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

endmodule

bind set_bipartition_gray_sequencer_top sbgs_checker u_sbgs_checker (.*);
